### rtl/txtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package txtea_pkg;

    localparam int ROUNDS        = 32;
    localparam int STAGE_CELLS   = 2 * ROUNDS;
    localparam int NUM_KEYS      = 3;
    localparam int NUM_CELLS     = NUM_KEYS * STAGE_CELLS;
    localparam int NUM_KEY_REGS  = 2 * NUM_KEYS;
    localparam int REG_IDX_W     = 3;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;
    localparam int KEY_SEL_W     = 2;

    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    typedef logic [31:0]          word_t;
    typedef logic [KEY_SEL_W-1:0] key_sel_t;
    typedef word_t [3:0]          key_words_t;
    typedef key_words_t [NUM_KEYS-1:0] key_set_t;

    // one block moving down the cell chain
    typedef struct packed {
        logic  valid;
        logic  op;
        word_t x;
        word_t y;
    } pipe_t;

    // fixed per-cell constants: half-round phase, keys and sums for both directions
    typedef struct packed {
        logic     half;
        key_sel_t enc_key;
        key_sel_t dec_key;
        word_t    enc_sum;
        word_t    dec_sum;
    } cell_cfg_t;

    function automatic word_t swap_bytes(input word_t w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic word_t mix(input word_t v, input word_t s, input word_t k);
        word_t t;
        t = (v << 4) ^ (v >> 5);
        return t + (s ^ v) + k;
    endfunction

    function automatic word_t delta_times(input int unsigned n);
        logic [63:0] p;
        p = 64'(DELTA) * 64'(n);
        return p[31:0];
    endfunction

    function automatic cell_cfg_t cell_cfg(input int unsigned c);
        cell_cfg_t   cfg;
        int unsigned g;
        int unsigned r;
        int unsigned h;
        g = c / STAGE_CELLS;
        r = (c % STAGE_CELLS) / 2;
        h = c % 2;
        cfg.half    = (h != 0);
        cfg.enc_key = KEY_SEL_W'(g);
        cfg.dec_key = KEY_SEL_W'(NUM_KEYS - 1 - g);
        cfg.enc_sum = (h != 0) ? delta_times(r + 1) : delta_times(r);
        cfg.dec_sum = (h != 0) ? delta_times(ROUNDS - r - 1) : delta_times(ROUNDS - r);
        return cfg;
    endfunction

endpackage

`default_nettype wire

### rtl/txtea_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module txtea_regs
    import txtea_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output key_set_t               keys
);

    logic [DATA_W-1:0]    key_reg [NUM_KEY_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic                 idx_ok;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign idx_ok = (32'(idx) < NUM_KEY_REGS);
    assign wr_en  = psel && penable && pwrite && idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            key_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = idx_ok ? key_reg[idx] : '0;
    end

    // key words are byte-swapped once here, shared by all cells
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            keys[k][0] = swap_bytes(key_reg[2*k][63:32]);
            keys[k][1] = swap_bytes(key_reg[2*k][31:0]);
            keys[k][2] = swap_bytes(key_reg[2*k+1][63:32]);
            keys[k][3] = swap_bytes(key_reg[2*k+1][31:0]);
        end
    end

endmodule

`default_nettype wire

### rtl/txtea_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module txtea_cell
    import txtea_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cfg_t cfg,
    input  wire key_set_t  keys,
    input  wire pipe_t     pipe_in,
    output pipe_t          pipe_out
);

    logic       valid_reg;
    logic       op_reg;
    word_t      x_reg;
    word_t      y_reg;
    word_t      x_next;
    word_t      y_next;

    logic       upd_x;
    word_t      sum;
    key_sel_t   ksel;
    key_words_t kw;
    logic [1:0] kidx;
    word_t      v;
    word_t      w;
    word_t      m;
    word_t      nw;

    // x is updated on encrypt first half and decrypt second half
    always_comb
    begin
        upd_x  = (cfg.half == pipe_in.op);
        sum    = pipe_in.op ? cfg.dec_sum : cfg.enc_sum;
        ksel   = pipe_in.op ? cfg.dec_key : cfg.enc_key;
        kw     = keys[ksel];
        kidx   = upd_x ? sum[1:0] : sum[12:11];
        v      = upd_x ? pipe_in.y : pipe_in.x;
        w      = upd_x ? pipe_in.x : pipe_in.y;
        m      = mix(v, sum, kw[kidx]);
        nw     = pipe_in.op ? (w - m) : (w + m);
        x_next = upd_x ? nw : pipe_in.x;
        y_next = upd_x ? pipe_in.y : nw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pipe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= pipe_in.op;
        x_reg  <= x_next;
        y_reg  <= y_next;
    end

    assign pipe_out = '{valid: valid_reg, op: op_reg, x: x_reg, y: y_reg};

endmodule

`default_nettype wire

### rtl/triple_xtea_block_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+--------------------------------
// request   | op, block_first, block_second                 | start high while busy low
// result    | out_first, out_second                         | done strobe, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | apb write, pready tied high
//
// one request accepted every cycle, busy never rises
// each result leaves the last cell of the chain, registered once in every cell
// one cell per half-round, three keys times ROUNDS rounds times two halves
// reset clears the key registers and the valid bits of the chain
// the receiver cannot stall, so nothing ever holds back in the chain

module triple_xtea_block_cipher_unit
    import txtea_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // request channel
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              op,
    input  wire logic [31:0]       block_first,
    input  wire logic [31:0]       block_second,

    // result channel
    output logic                   done,
    output logic      [31:0]       out_first,
    output logic      [31:0]       out_second,

    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    key_set_t keys;
    pipe_t    pipe [NUM_CELLS+1];

    // fully pipelined, always ready for a request
    assign busy = 1'b0;

    // key register file, byte-swapped words fan out to every cell
    txtea_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys)
    );

    // head of the chain: only bit 0 of op matters, it is a single bit here
    assign pipe[0] = '{valid: start && !busy, op: op, x: block_first, y: block_second};

    // chain of half-round cells; each cell gets its own fixed sums and key picks
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        localparam cell_cfg_t CFG = cell_cfg(i);

        txtea_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (CFG),
            .keys     (keys),
            .pipe_in  (pipe[i]),
            .pipe_out (pipe[i+1])
        );
    end

    // tail of the chain drives the result ports directly
    assign done       = pipe[NUM_CELLS].valid;
    assign out_first  = pipe[NUM_CELLS].x;
    assign out_second = pipe[NUM_CELLS].y;

endmodule

`default_nettype wire

### dv/triple_xtea_block_checker.sv
`timescale 1ns / 1ps

module triple_xtea_block_checker
    import txtea_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              op,
    input  wire logic [31:0]       block_first,
    input  wire logic [31:0]       block_second,
    input  wire logic              done,
    input  wire logic [31:0]       out_first,
    input  wire logic [31:0]       out_second,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output int unsigned            blocks_in_flight,
    output int unsigned            mismatch_count
);

    typedef struct {
        word_t first;
        word_t second;
    } cipher_block_t;

    logic [63:0]   key_reg [NUM_KEY_REGS];
    cipher_block_t predicted_blocks [$];
    cipher_block_t head;
    logic [2:0]    reg_idx;
    int unsigned   errs;

    function automatic word_t byte_rev(input word_t w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic word_t feistel(input word_t v, input word_t s, input word_t k);
        return ((v << 4) ^ (v >> 5)) + (s ^ v) + k;
    endfunction

    // three xtea stages, keys one two three forward, three two one backward
    function automatic cipher_block_t triple_xtea(input logic dir, input word_t first,
                                                  input word_t second);
        cipher_block_t res;
        word_t         x;
        word_t         y;
        word_t         s;
        word_t         kw [4];
        int            st;
        int            g;
        int            r;
        x = first;
        y = second;
        for (st = 0; st < NUM_KEYS; st++)
        begin
            g = dir ? (NUM_KEYS - 1 - st) : st;
            kw[0] = byte_rev(key_reg[2*g][63:32]);
            kw[1] = byte_rev(key_reg[2*g][31:0]);
            kw[2] = byte_rev(key_reg[2*g+1][63:32]);
            kw[3] = byte_rev(key_reg[2*g+1][31:0]);
            if (!dir)
            begin
                s = '0;
                for (r = 0; r < ROUNDS; r++)
                begin
                    x = x + feistel(y, s, kw[s[1:0]]);
                    s = s + DELTA;
                    y = y + feistel(x, s, kw[s[12:11]]);
                end
            end
            else
            begin
                s = word_t'(DELTA * ROUNDS);
                for (r = 0; r < ROUNDS; r++)
                begin
                    y = y - feistel(x, s, kw[s[12:11]]);
                    s = s - DELTA;
                    x = x - feistel(y, s, kw[s[1:0]]);
                end
            end
        end
        res.first  = x;
        res.second = y;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEY_REGS; i++)
                key_reg[i] = '0;
            predicted_blocks.delete();
            errs = 0;
            blocks_in_flight <= 0;
            mismatch_count   <= 0;
        end
        else
        begin
            // key register writes, indexes past the last key are dropped
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[ADDR_W-1:3];
                if (reg_idx < NUM_KEY_REGS)
                    key_reg[reg_idx] = pwdata;
            end
            if (done)
            begin
                if (predicted_blocks.size() == 0)
                begin
                    $error("result with no pending request: out_first %08h out_second %08h",
                           out_first, out_second);
                    errs++;
                end
                else
                begin
                    head = predicted_blocks.pop_front();
                    if (out_first !== head.first)
                    begin
                        $error("out_first mismatch: expected %08h, actual %08h",
                               head.first, out_first);
                        errs++;
                    end
                    if (out_second !== head.second)
                    begin
                        $error("out_second mismatch: expected %08h, actual %08h",
                               head.second, out_second);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                predicted_blocks.push_back(triple_xtea(op, block_first, block_second));
            blocks_in_flight <= predicted_blocks.size();
            mismatch_count   <= errs;
        end
    end

endmodule

### dv/tb_triple_xtea_block_cipher_unit.sv
`timescale 1ns / 1ps

module tb_triple_xtea_block_cipher_unit;
    import txtea_pkg::*;

    // kinds of key settings for a phase
    typedef enum int {
        KEYS_ZERO,
        KEYS_ONES,
        KEYS_ALT,
        KEYS_ONEHOT,
        KEYS_RANDOM
    } key_kind_e;

    localparam int ITEMS_PER_PHASE = 215;
    localparam int TAIL_CYCLES     = 250;   // margin past the depth of the cell chain

    // every input starts at a known value
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              op           = 1'b0;
    logic [31:0]       block_first  = '0;
    logic [31:0]       block_second = '0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;

    wire logic              busy;
    wire logic              done;
    wire logic [31:0]       out_first;
    wire logic [31:0]       out_second;
    wire logic [DATA_W-1:0] prdata;
    wire logic              pready;

    int unsigned blocks_in_flight;
    int unsigned mismatch_count;
    int          burst_left;

    always #5 clk = ~clk;

    triple_xtea_block_cipher_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .block_first  (block_first),
        .block_second (block_second),
        .done         (done),
        .out_first    (out_first),
        .out_second   (out_second),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // watches request, result and config traffic, predicts and compares
    triple_xtea_block_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .block_first      (block_first),
        .block_second     (block_second),
        .done             (done),
        .out_first        (out_first),
        .out_second       (out_second),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .blocks_in_flight (blocks_in_flight),
        .mismatch_count   (mismatch_count)
    );

    // all tasks below are entered and left right after a rising edge

    // present one request and hold it until the block takes it
    // start stays high on return so back-to-back requests need no re-raise
    task automatic send_block(input logic dir, input word_t first, input word_t second);
        start        <= 1'b1;
        op           <= dir;
        block_first  <= first;
        block_second <= second;
        do
            @(posedge clk);
        while (busy);
    endtask

    // lower start and idle, n sets how long; nothing happens for n of zero
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // mostly short gaps, now and then a long one
    task automatic random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            idle_cycles(0);
        else if (pick < 90)
            idle_cycles($urandom_range(1, 3));
        else if (pick < 98)
            idle_cycles($urandom_range(4, 20));
        else
            idle_cycles($urandom_range(30, 300));
    endtask

    // stop sending and wait until every predicted block has come back
    // the first edge lets the in-flight count catch the last request
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (blocks_in_flight != 0)
            @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] key_pattern(input key_kind_e kind, input int idx);
        case (kind)
            KEYS_ZERO:   return '0;
            KEYS_ONES:   return '1;
            KEYS_ALT:    return idx[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
            KEYS_ONEHOT: return 64'd1 << $urandom_range(0, 63);
            default:     return {$urandom, $urandom};
        endcase
    endfunction

    // reload all six key registers while idle, then poke the unused indexes
    // which must leave the keys alone
    task automatic load_keys(input key_kind_e kind);
        drain();
        for (int i = 0; i < NUM_KEY_REGS; i++)
            write_reg(i, key_pattern(kind, i));
        write_reg(NUM_KEY_REGS, {$urandom, $urandom});
        write_reg(NUM_KEY_REGS + 1, '1);
    endtask

    // data words lean toward edges: zero, all ones, single bits set or cleared
    function automatic word_t data_word();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(0, 31);
            3:       return ~(word_t'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input key_kind_e kind, input int count);
        load_keys(kind);
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            send_block(1'($urandom_range(0, 1)), data_word(), data_word());
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 39) == 0)
                burst_left = $urandom_range(20, 80);    // back-to-back stretch
            else if ($urandom_range(0, 149) == 0)
                drain();                                // let the pipe run dry
            else
                random_gap();
        end
    endtask

    // run limit, far above the slowest legal run
    initial
    begin
        #25_000_000;
        $display("triple_xtea_block_cipher_unit test failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset keys are all zero
        for (int d = 0; d < 2; d++)
        begin
            send_block(1'(d), 32'h0000_0000, 32'h0000_0000);
            send_block(1'(d), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            idle_cycles(1);
            send_block(1'(d), 32'h8000_0000, 32'h0000_0001);
            send_block(1'(d), 32'h0000_0001, 32'h8000_0000);
            idle_cycles(3);
            send_block(1'(d), 32'hDEAD_BEEF, 32'h0123_4567);
        end

        // directed, all key bits set; out-of-range writes must not disturb them
        load_keys(KEYS_ONES);
        send_block(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // directed, distinct random keys so stage order matters
        load_keys(KEYS_RANDOM);
        send_block(1'b0, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(1'b1, 32'h0123_4567, 32'h89AB_CDEF);
        idle_cycles(2);
        send_block(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_block(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);

        // random phases over several key settings
        random_phase(KEYS_RANDOM, ITEMS_PER_PHASE);
        random_phase(KEYS_ALT, ITEMS_PER_PHASE);
        random_phase(KEYS_ONEHOT, ITEMS_PER_PHASE);
        random_phase(KEYS_RANDOM, ITEMS_PER_PHASE);
        random_phase(KEYS_ZERO, ITEMS_PER_PHASE);
        random_phase(KEYS_ONES, ITEMS_PER_PHASE);
        random_phase(KEYS_RANDOM, ITEMS_PER_PHASE);

        // wait out the pipe, then a margin for stray results
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && blocks_in_flight == 0)
            $display("triple_xtea_block_cipher_unit test passed");
        else
            $display("triple_xtea_block_cipher_unit test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/txtea_pkg.sv
rtl/txtea_regs.sv
rtl/txtea_cell.sv
rtl/triple_xtea_block_cipher_unit.sv
dv/triple_xtea_block_checker.sv
dv/tb_triple_xtea_block_cipher_unit.sv
